// File: design/mrc_pkg.sv
package mrc_pkg;

  localparam logic [7:0] HDR_RESTART = 8'hCA;
  localparam logic [7:0] HDR_FRAME   = 8'hFE;
  localparam logic [7:0] CMD_SPEED   = 8'h73;
  localparam logic [7:0] CMD_PING    = 8'h70;
  localparam logic [7:0] ID_RIGHT    = 8'h72;
  localparam logic [7:0] ID_LEFT     = 8'h6C;
  localparam logic [7:0] ID_TURRET   = 8'h74;

  localparam int unsigned FRAME_LEN  = 5;
  localparam int unsigned NUM_MOTORS = 3;

  localparam logic [2:0] FRAME_LAST = 3'd4;
  localparam logic [2:0] FRAME_FULL = 3'd5;

  localparam logic [1:0] MOTOR_RIGHT  = 2'd0;
  localparam logic [1:0] MOTOR_LEFT   = 2'd1;
  localparam logic [1:0] MOTOR_TURRET = 2'd2;

  localparam logic [1:0] REG_RAMP_DIV   = 2'd0;
  localparam logic [1:0] REG_WD_TIMEOUT = 2'd1;

  localparam logic [15:0] RAMP_DIV_RST   = 16'd10000;
  localparam logic [23:0] WD_TIMEOUT_RST = 24'd5000000;

  typedef struct packed {
    logic       set_en;
    logic [1:0] motor;
    logic [7:0] speed;
    logic       dir;
    logic       kick;
  } cmd_t;

  typedef struct packed {
    logic ramp_en;
    logic wd_fire;
  } tick_ctl_t;

endpackage

// File: design/mrc_frame.sv
module mrc_frame
  import mrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       has_byte,
  input  logic [7:0] byte_value,
  output cmd_t       cmd
);

  logic [7:0] bytes_r [0:FRAME_LEN-2];
  logic [2:0] count_r;
  logic [2:0] count_nxt;
  logic       store;
  logic       done;

  assign store = step && has_byte && (byte_value != HDR_RESTART) && (count_r < FRAME_FULL);
  assign done  = store && (count_r == FRAME_LAST);

  always_comb begin
    count_nxt = count_r;
    if (step && has_byte) begin
      if (byte_value == HDR_RESTART) begin
        count_nxt = 3'd0;
      end else if (count_r < FRAME_FULL) begin
        count_nxt = count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store && (count_r != FRAME_LAST)) begin
      bytes_r[count_r[1:0]] <= byte_value;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.speed  = bytes_r[3];
    cmd.dir    = (byte_value != 8'd0);
    cmd.motor  = MOTOR_RIGHT;
    if (bytes_r[2] == ID_LEFT) begin
      cmd.motor = MOTOR_LEFT;
    end else if (bytes_r[2] == ID_TURRET) begin
      cmd.motor = MOTOR_TURRET;
    end
    if (done && (bytes_r[0] == HDR_FRAME)) begin
      cmd.set_en = (bytes_r[1] == CMD_SPEED);
      cmd.kick   = (bytes_r[1] == CMD_SPEED) || (bytes_r[1] == CMD_PING);
    end
  end

endmodule

// File: design/mrc_motor.sv
module mrc_motor
  import mrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  tick_ctl_t  ctl,
  input  logic       set_en,
  input  logic [7:0] set_speed,
  input  logic       set_dir,
  output logic [7:0] speed_nxt,
  output logic       dir_nxt
);

  logic [7:0] tgt_r;
  logic       tdir_r;
  logic [7:0] cur_r;
  logic       cdir_r;
  logic [7:0] tgt_nxt;
  logic       tdir_nxt;

  always_comb begin
    speed_nxt = cur_r;
    dir_nxt   = cdir_r;
    tgt_nxt   = tgt_r;
    tdir_nxt  = tdir_r;
    if (ctl.ramp_en) begin
      if (cdir_r != tdir_r) begin
        if (cur_r != 8'd0) begin
          speed_nxt = cur_r - 8'd1;
        end
        if (speed_nxt == 8'd0) begin
          dir_nxt = tdir_r;
        end
      end else if (cur_r < tgt_r) begin
        speed_nxt = cur_r + 8'd1;
      end else if (cur_r > tgt_r) begin
        speed_nxt = cur_r - 8'd1;
      end
    end
    if (ctl.wd_fire) begin
      tgt_nxt   = 8'd0;
      speed_nxt = 8'd0;
    end
    if (set_en) begin
      tgt_nxt  = set_speed;
      tdir_nxt = set_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= 8'd0;
      tdir_r <= 1'b0;
      cur_r  <= 8'd0;
      cdir_r <= 1'b0;
    end else if (step) begin
      tgt_r  <= tgt_nxt;
      tdir_r <= tdir_nxt;
      cur_r  <= speed_nxt;
      cdir_r <= dir_nxt;
    end
  end

endmodule

// File: design/motor_ramp_command_controller.sv
// A request accepted into the input register has its result registered in the output
// register, which drives out_tdata.
// Throughput: one request per cycle while out_tready stays high. When a result waits,
// the input register takes one more request and then in_tready drops.
// Reset: synchronous, active low; all speeds, targets, counters and the frame
// count clear, and the ramp divider and watchdog timeout return to 10000 and 5000000.
module motor_ramp_command_controller
  import mrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // right_fwd, right_rev, left_fwd, left_rev,
                                  // turret_fwd, turret_rev duty, 8 bits each
  output logic [0:0]  out_tuser,  // [0] watchdog_fired
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_op_r;
  logic        advance;

  logic [15:0] ramp_div_r;
  logic [23:0] wd_timeout_r;
  logic [15:0] ramp_ticks_r;
  logic [23:0] idle_ticks_r;
  logic [15:0] ramp_inc;
  logic [23:0] idle_inc;

  tick_ctl_t   ctl;
  cmd_t        cmd;

  logic [7:0]  spd [0:NUM_MOTORS-1];
  logic        dir [0:NUM_MOTORS-1];
  logic [47:0] duty_nxt;

  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_fired_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_op_r   <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_div_r   <= RAMP_DIV_RST;
      wd_timeout_r <= WD_TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_RAMP_DIV) begin
        ramp_div_r <= cfg_data[15:0];
      end else if (cfg_index == REG_WD_TIMEOUT) begin
        wd_timeout_r <= cfg_data;
      end
    end
  end

  assign ramp_inc    = ramp_ticks_r + 16'd1;
  assign idle_inc    = idle_ticks_r + 24'd1;
  assign ctl.ramp_en = (ramp_inc == ramp_div_r);
  assign ctl.wd_fire = (idle_inc == wd_timeout_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_ticks_r <= 16'd0;
      idle_ticks_r <= 24'd0;
    end else if (advance) begin
      ramp_ticks_r <= ctl.ramp_en ? 16'd0 : ramp_inc;
      idle_ticks_r <= cmd.kick ? 24'd0 : idle_inc;
    end
  end

  mrc_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .has_byte   (in_op_r),
    .byte_value (in_byte_r),
    .cmd        (cmd)
  );

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
    mrc_motor u_motor (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (advance),
      .ctl       (ctl),
      .set_en    (cmd.set_en && (cmd.motor == 2'(m))),
      .set_speed (cmd.speed),
      .set_dir   (cmd.dir),
      .speed_nxt (spd[m]),
      .dir_nxt   (dir[m])
    );
    assign duty_nxt[16*m +: 8]     = dir[m] ? 8'd0 : spd[m];
    assign duty_nxt[16*m + 8 +: 8] = dir[m] ? spd[m] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r  <= duty_nxt;
      out_fired_r <= ctl.wd_fire;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_fired_r;

  a_fired_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 48'd0))
    else $error("watchdog result carries a nonzero duty");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[7:0] == 8'd0 || out_tdata[15:8] == 8'd0) &&
                    (out_tdata[23:16] == 8'd0 || out_tdata[31:24] == 8'd0) &&
                    (out_tdata[39:32] == 8'd0 || out_tdata[47:40] == 8'd0)))
    else $error("a motor drives forward and reverse at once");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("pending input request dropped");

  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ctl.ramp_en) |=> (ramp_ticks_r == 16'd0))
    else $error("ramp counter not cleared after a ramp step");

endmodule
